// ===== rtl/core/pidl_pkg.sv =====
// Shared types and codes for the positional insert/delete list.
package pidl_pkg;

	localparam int DEPTH_DEFAULT = 128;
	localparam int VAL_W         = 32;
	localparam int POS_W         = 8;
	localparam int MIDX_W        = 7;
	localparam int ECNT_W        = 8;

	typedef logic [1:0] op_t;
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_READ   = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD_POS   = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic ins;
		logic del;
	} pidl_cmd_t;

endpackage

// ===== rtl/core/pidl_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, takes part in the match chain.
module pidl_cell #(
	parameter int IW = 7,
	parameter int CW = 8
) (
	input  logic                      clk,
	input  pidl_pkg::pidl_cmd_t       cmd,
	input  logic [IW-1:0]             idx,
	input  logic [IW-1:0]             slot,
	input  logic [IW-1:0]             rd_idx,
	input  logic [CW-1:0]             count,
	input  logic [pidl_pkg::VAL_W-1:0] value,
	input  logic [pidl_pkg::VAL_W-1:0] left,
	input  logic [pidl_pkg::VAL_W-1:0] right,
	input  logic                      found_in,
	output logic [pidl_pkg::VAL_W-1:0] data,
	output logic                      found_out,
	output logic [pidl_pkg::VAL_W-1:0] rd_data,
	output logic [IW-1:0]             hit_idx
);
	import pidl_pkg::*;

	logic [VAL_W-1:0] data_q;
	logic             live;
	logic             match;

	assign live      = CW'(idx) < count;
	assign match     = live && (data_q == value);
	assign found_out = found_in | match;
	assign data      = data_q;
	assign rd_data   = (rd_idx == idx) ? data_q : '0;
	assign hit_idx   = (match && !found_in) ? idx : '0;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (idx == slot) begin
				data_q <= value;
			end else if (idx > slot) begin
				data_q <= left;
			end
		end else if (cmd.del && found_out) begin
			data_q <= right;
		end
	end

endmodule

// ===== rtl/core/positional_insert_delete_list_top.sv =====
// Top level: request decode, row of list cells, count and registered result.
//
//  channel | dir | fields (tdata, lowest bit first)
//  s_*     | in  | op[1:0], value[33:2], position[41:34]
//  m_*     | out | status[1:0], read_value[33:2], match_index[40:34], entry_count[48:41]
//
// One request per cycle while s_tready is high; every request yields one result, registered in the next cycle.
// The first-match chain runs through all DEPTH cells within the cycle.
// arst_n clears the count and the result valid flag; entries and result fields need no reset.
// s_tready stays high while the result register is empty or being taken.
module positional_insert_delete_list_top #(
	parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // op[1:0], value[33:2], position[41:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // status, read_value, match_index, entry_count
);
	import pidl_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;

	op_t              op;
	logic [VAL_W-1:0] value;
	logic [POS_W-1:0] position;
	logic             accept;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_nxt;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cnt_x;
	logic [IW-1:0]    slot;
	logic [IW-1:0]    rd_idx;
	logic             ins_ok;
	pidl_cmd_t        cmd;

	logic [VAL_W-1:0] cell_data [DEPTH];
	logic [VAL_W-1:0] cell_rd   [DEPTH];
	logic [IW-1:0]    cell_hit  [DEPTH];
	logic [DEPTH:0]   fchain;
	logic [VAL_W-1:0] rd_or;
	logic [IW-1:0]    hit_or;

	status_t          status_nxt;
	logic [VAL_W-1:0] rdv_nxt;
	logic [IW-1:0]    midx_nxt;

	logic             out_valid_q;
	status_t          status_q;
	logic [VAL_W-1:0] rdv_q;
	logic [MIDX_W-1:0] midx_q;
	logic [ECNT_W-1:0] ecnt_q;

	assign op       = s_tdata[1:0];
	assign value    = s_tdata[33:2];
	assign position = s_tdata[41:34];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_x  = XW'(position);
	assign cnt_x  = XW'(count_q);
	assign slot   = IW'(pos_x - XW'(1));
	assign rd_idx = IW'(position);

	assign cmd.ins = accept && ins_ok;
	assign cmd.del = accept && (op == OP_DELETE);

	assign fchain[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [VAL_W-1:0] left_d;
			logic [VAL_W-1:0] right_d;
			if (g == 0) begin : g_first
				assign left_d = '0;
			end else begin : g_mid
				assign left_d = cell_data[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_inner
				assign right_d = cell_data[g+1];
			end
			pidl_cell #(
				.IW(IW),
				.CW(CW)
			) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.idx      (IW'(g)),
				.slot     (slot),
				.rd_idx   (rd_idx),
				.count    (count_q),
				.value    (value),
				.left     (left_d),
				.right    (right_d),
				.found_in (fchain[g]),
				.data     (cell_data[g]),
				.found_out(fchain[g+1]),
				.rd_data  (cell_rd[g]),
				.hit_idx  (cell_hit[g])
			);
		end
	endgenerate

	always_comb begin
		rd_or  = '0;
		hit_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or  = rd_or | cell_rd[i];
			hit_or = hit_or | cell_hit[i];
		end
	end

	always_comb begin
		status_nxt = ST_BAD_POS;
		rdv_nxt    = '0;
		midx_nxt   = '0;
		count_nxt  = count_q;
		ins_ok     = 1'b0;
		case (op)
			OP_INSERT: begin
				if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
					status_nxt = ST_BAD_POS;
				end else if (count_q == CW'(DEPTH)) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_OK;
					ins_ok     = 1'b1;
					count_nxt  = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (fchain[DEPTH]) begin
					status_nxt = ST_OK;
					midx_nxt   = hit_or;
					count_nxt  = count_q - CW'(1);
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_BAD_POS;
				end else begin
					status_nxt = ST_OK;
					rdv_nxt    = rd_or;
				end
			end
			default: begin
				status_nxt = ST_BAD_POS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			rdv_q    <= rdv_nxt;
			midx_q   <= MIDX_W'(midx_nxt);
			ecnt_q   <= ECNT_W'(count_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, ecnt_q, midx_q, rdv_q, status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_nxt != ST_OK |=> $stable(count_q))
		else $error("failed request changed the count");

	a_delete_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del && fchain[DEPTH] |-> CW'(hit_or) < count_q)
		else $error("match index outside the list");

endmodule
